FILE: design/scv_pkg.sv
// ----------------------------------------------------------------------------
// scv_pkg
// Shared types, constants and the byte-wise CRC-32 update for the sector
// header validator.
// ----------------------------------------------------------------------------
package scv_pkg;

  localparam logic [31:0] SEC_MAGIC = 32'h344D_4354;
  localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;

  localparam int unsigned POS_W  = 12;
  localparam int unsigned END_W  = 19;
  localparam int unsigned CNT_W  = 16;
  localparam int unsigned ECNT_W = 10;

  localparam logic [POS_W-1:0] HDR_LEN = 12'd20;

  typedef enum logic [2:0] {
    WORD_MAGIC = 3'd0,
    WORD_NONCE = 3'd1,
    WORD_X     = 3'd2,
    WORD_Z     = 3'd3,
    WORD_COUNT = 3'd4
  } hdr_word_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } beat_t;

  typedef struct packed {
    logic              valid_res;
    logic [31:0]       chunk_x;
    logic [31:0]       chunk_z;
    logic [ECNT_W-1:0] entry_count;
  } result_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] v;
    v = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      v = {1'b0, v[31:1]} ^ (v[0] ? CRC_POLY : 32'd0);
    end
    return v;
  endfunction

endpackage

FILE: design/scv_in_reg.sv
// ----------------------------------------------------------------------------
// scv_in_reg
// Input register for sector bytes; holds a last beat while the result
// register is still occupied.
// ----------------------------------------------------------------------------
module scv_in_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,
  input  logic          in_tlast,
  input  logic          out_free,
  output scv_pkg::beat_t beat
);

  logic       vld_r;
  logic [7:0] byte_r;
  logic       last_r;
  logic       go;

  assign go        = !last_r || out_free;
  assign in_tready = !vld_r || go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_tready) begin
      vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      byte_r <= in_tdata;
      last_r <= in_tlast;
    end
  end

  assign beat.valid = vld_r && go;
  assign beat.data  = byte_r;
  assign beat.last  = last_r;

endmodule

FILE: design/scv_core.sv
// ----------------------------------------------------------------------------
// scv_core
// Per-byte header parse, CRC-32 update and check logic with sector state.
// ----------------------------------------------------------------------------
module scv_core #(
  parameter int ENTRY_LIMIT  = 512,
  parameter int SECTOR_BYTES = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  input  scv_pkg::beat_t   beat,
  input  logic [31:0]      nonce,
  output logic             res_fire,
  output scv_pkg::result_t res
);

  localparam logic [scv_pkg::END_W-1:0] MAX_L = scv_pkg::END_W'(ENTRY_LIMIT);
  localparam logic [scv_pkg::END_W-1:0] SEC_L = scv_pkg::END_W'(SECTOR_BYTES);
  localparam logic [scv_pkg::POS_W-1:0] LAST_POS = scv_pkg::POS_W'(SECTOR_BYTES - 1);
  localparam logic [scv_pkg::END_W-1:0] DEND_RST = scv_pkg::END_W'(scv_pkg::HDR_LEN);

  logic [scv_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [31:0]               crc_r, crc_nxt;
  logic [31:0]               shift_r, shift_nxt;
  logic [31:0]               x_r, x_nxt;
  logic [31:0]               z_r, z_nxt;
  logic [scv_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [scv_pkg::END_W-1:0] dend_r, dend_nxt;
  logic                      fail_r, fail_nxt;

  logic                      in_hdr;
  logic                      in_data;
  logic                      in_crcw;
  logic                      done;
  logic [scv_pkg::END_W-1:0] pos_w;
  logic [scv_pkg::END_W-1:0] new_dend;

  assign pos_w    = scv_pkg::END_W'(pos_r);
  assign in_hdr   = pos_r < scv_pkg::HDR_LEN;
  assign in_data  = !in_hdr && (pos_w < dend_r);
  assign in_crcw  = !in_hdr && (pos_w >= dend_r) && (pos_w < dend_r + 19'd4);
  assign done     = !in_hdr && (pos_w >= dend_r + 19'd3);
  // low half of the count word sits in shift_r[23:8] before its last byte
  assign new_dend = DEND_RST + {1'b0, shift_r[23:8], 2'b00};

  always_comb begin
    shift_nxt = {beat.data, shift_r[31:8]};
    crc_nxt   = (in_hdr || in_data) ? scv_pkg::crc_byte(crc_r, beat.data) : crc_r;
    x_nxt     = x_r;
    z_nxt     = z_r;
    cnt_nxt   = cnt_r;
    dend_nxt  = dend_r;
    fail_nxt  = fail_r;
    pos_nxt   = pos_r;

    if (in_hdr) begin
      if (pos_r[1:0] == 2'b11) begin
        case (scv_pkg::hdr_word_t'(pos_r[4:2]))
          scv_pkg::WORD_MAGIC: begin
            if (shift_nxt != scv_pkg::SEC_MAGIC) fail_nxt = 1'b1;
          end
          scv_pkg::WORD_NONCE: begin
            if (shift_nxt != nonce) fail_nxt = 1'b1;
          end
          scv_pkg::WORD_X: begin
            x_nxt = shift_nxt;
          end
          scv_pkg::WORD_Z: begin
            z_nxt = shift_nxt;
          end
          scv_pkg::WORD_COUNT: begin
            cnt_nxt  = shift_nxt[15:0];
            dend_nxt = new_dend;
            if (scv_pkg::END_W'(shift_nxt[15:0]) > MAX_L) fail_nxt = 1'b1;
            if (new_dend + 19'd4 > SEC_L) fail_nxt = 1'b1;
          end
          default: begin
          end
        endcase
      end
    end else if (in_crcw) begin
      if ((pos_w == dend_r + 19'd3) && ((crc_r ^ scv_pkg::CRC_INIT) != shift_nxt)) begin
        fail_nxt = 1'b1;
      end
    end

    if (!beat.last) begin
      if (pos_r < LAST_POS) begin
        pos_nxt = pos_r + 12'd1;
      end else begin
        fail_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    res_fire        = beat.valid && beat.last;
    res.valid_res   = done && !fail_nxt;
    res.chunk_x     = res.valid_res ? x_r : 32'd0;
    res.chunk_z     = res.valid_res ? z_r : 32'd0;
    res.entry_count = res.valid_res ? cnt_r[scv_pkg::ECNT_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (beat.valid && beat.last)) begin
      pos_r   <= '0;
      crc_r   <= scv_pkg::CRC_INIT;
      shift_r <= '0;
      x_r     <= '0;
      z_r     <= '0;
      cnt_r   <= '0;
      dend_r  <= DEND_RST;
      fail_r  <= 1'b0;
    end else if (beat.valid) begin
      pos_r   <= pos_nxt;
      crc_r   <= crc_nxt;
      shift_r <= shift_nxt;
      x_r     <= x_nxt;
      z_r     <= z_nxt;
      cnt_r   <= cnt_nxt;
      dend_r  <= dend_nxt;
      fail_r  <= fail_nxt;
    end
  end

endmodule

FILE: design/scv_out_reg.sv
// ----------------------------------------------------------------------------
// scv_out_reg
// Result register driving the output stream; one entry, freed on handshake.
// ----------------------------------------------------------------------------
module scv_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             res_fire,
  input  scv_pkg::result_t res,
  output logic             out_free,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [79:0]      out_tdata,
  output logic             out_tuser
);

  logic             vld_r;
  scv_pkg::result_t res_r;

  assign out_free = !vld_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (res_fire) begin
      vld_r <= 1'b1;
    end else if (out_tready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      res_r <= res;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tuser  = res_r.valid_res;
  assign out_tdata  = {6'd0, res_r.entry_count, res_r.chunk_z, res_r.chunk_x};

endmodule

FILE: design/sector_header_crc_validator_top.sv
// ----------------------------------------------------------------------------
// sector_header_crc_validator_top
// Byte-stream sector validator: header checks, entry count bound and CRC-32.
// ----------------------------------------------------------------------------
// Throughput: one byte beat per cycle while results drain; a last beat waits
//   in the input register while the result register holds an unaccepted result.
// Path: a last beat's result reaches out_ through the input register, then the
//   result register; a busy result register holds the last beat in the input register.
// Reset: synchronous active-low rst_n clears sector state and the nonce
//   register; no clearing pass.
// ----------------------------------------------------------------------------
module sector_header_crc_validator_top #(
  parameter int ENTRY_LIMIT  = 512,
  parameter int SECTOR_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // [31:0] chunk_x, [63:32] chunk_z, [73:64] entry_count
  output logic        out_tuser,  // valid_res
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data    // expected_nonce
);

  scv_pkg::beat_t   beat;
  scv_pkg::result_t res;
  logic             res_fire;
  logic             out_free;
  logic [31:0]      nonce_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nonce_r <= '0;
    end else if (cfg_valid) begin
      nonce_r <= cfg_data;
    end
  end

  scv_in_reg u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_free  (out_free),
    .beat      (beat)
  );

  scv_core #(
    .ENTRY_LIMIT  (ENTRY_LIMIT),
    .SECTOR_BYTES (SECTOR_BYTES)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .beat     (beat),
    .nonce    (nonce_r),
    .res_fire (res_fire),
    .res      (res)
  );

  scv_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_fire   (res_fire),
    .res        (res),
    .out_free   (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_fire |-> (!out_tvalid || out_tready))
    else $error("result written while output register busy");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (beat.valid && beat.last) |=> out_tvalid)
    else $error("last beat did not produce a result");

  a_fail_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == 80'd0))
    else $error("failed sector carries nonzero fields");

endmodule
